// File: src/ptbs_pkg.sv
// Package for the polling-target bitmap scheduler.
// Holds operation codes, the command and scan-summary structs and the low-bit helper.
// No dependencies.
`default_nettype none
package ptbs_pkg;

	localparam int ID_W       = 8;
	localparam int FUNC_W     = 3;
	localparam int BYTE_SEL_W = ID_W - 3;
	localparam int MAX_ID_DEF = 247;

	localparam logic [FUNC_W-1:0] FN_SET_ONE   = 3'd0;
	localparam logic [FUNC_W-1:0] FN_SET_RANGE = 3'd1;
	localparam logic [FUNC_W-1:0] FN_REMOVE    = 3'd2;
	localparam logic [FUNC_W-1:0] FN_TEST      = 3'd3;
	localparam logic [FUNC_W-1:0] FN_ADVANCE   = 3'd4;
	localparam logic [FUNC_W-1:0] FN_REWIND    = 3'd5;
	localparam logic [FUNC_W-1:0] FN_CLEAR     = 3'd6;

	typedef struct packed {
		logic [FUNC_W-1:0] func;
		logic [ID_W-1:0]   target;
		logic [ID_W-1:0]   last;
		logic [ID_W:0]     start;
		logic              ign;
		logic              wipe;
	} scan_cmd_t;

	typedef struct packed {
		logic            any;
		logic            f0v;
		logic [ID_W-1:0] f0;
		logic            g0v;
		logic [ID_W-1:0] g0;
		logic            f1v;
		logic [ID_W-1:0] f1;
		logic            g1v;
		logic [ID_W-1:0] g1;
		logic            hit;
	} scan_acc_t;

	typedef struct packed {
		logic       v0;
		logic [2:0] i0;
		logic       v1;
		logic [2:0] i1;
	} low_pair_t;

	// Lowest and second lowest set bit of a byte.
	function automatic low_pair_t low_pair(input logic [7:0] b);
		low_pair_t r;
		r = '0;
		for (int j = 7; j >= 0; j--) begin
			if (b[j]) begin
				r.i1 = r.i0;
				r.v1 = r.v0;
				r.i0 = 3'(j);
				r.v0 = 1'b1;
			end
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// File: src/ptbs_scan.sv
// Bitmap memory with a one-byte-per-cycle read-modify-write pass.
// Summarises the updated bytes into lowest and second-lowest set addresses, overall and from
// a start address, with any-set and test-hit flags. Depends on ptbs_pkg.
`default_nettype none
module ptbs_scan
	import ptbs_pkg::*;
#(
	parameter int MAX_ID = MAX_ID_DEF,
	localparam int DEPTH = MAX_ID / 8 + 1,
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          rd_en,
	input  wire logic [AW-1:0] rd_addr,
	input  wire logic          clr_acc,
	input  wire scan_cmd_t     cmd,
	output scan_acc_t          acc
);

	logic [7:0]      mem [DEPTH];
	logic [7:0]      rd_data_s1;
	logic [AW-1:0]   addr_s1;
	logic            vld_s1;
	logic [7:0]      nb;
	logic [7:0]      bitm;
	logic [7:0]      rmask;
	logic [7:0]      smask;
	logic [ID_W-1:0] base;
	logic            sel;
	low_pair_t       lp_all;
	low_pair_t       lp_up;
	scan_acc_t       acc_q;

	assign base = ID_W'({addr_s1, 3'b000});
	assign sel  = (cmd.target[ID_W-1:3] == BYTE_SEL_W'(addr_s1));
	assign bitm = sel ? (8'b1 << cmd.target[2:0]) : 8'b0;

	always_comb begin
		logic [ID_W-1:0] idj;
		for (int j = 0; j < 8; j++) begin
			idj      = {base[ID_W-1:3], 3'(j)};
			rmask[j] = (idj >= cmd.target) && (idj <= cmd.last);
			smask[j] = ({1'b0, idj} >= cmd.start);
		end
	end

	always_comb begin
		nb = rd_data_s1;
		if (!cmd.ign) begin
			case (cmd.func)
				FN_SET_ONE:   nb = rd_data_s1 | bitm;
				FN_REMOVE:    nb = rd_data_s1 & ~bitm;
				FN_SET_RANGE: nb = rd_data_s1 | rmask;
				default:      nb = rd_data_s1;
			endcase
		end
		if (cmd.wipe) begin
			nb = 8'b0;
		end
	end

	assign lp_all = low_pair(nb);
	assign lp_up  = low_pair(nb & smask);

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			mem[addr_s1] <= nb;
		end
		if (rd_en) begin
			rd_data_s1 <= mem[rd_addr];
		end
		addr_s1 <= rd_addr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			acc_q  <= '0;
		end else begin
			vld_s1 <= rd_en;
			if (clr_acc) begin
				acc_q <= '0;
			end else if (vld_s1) begin
				acc_q.any <= acc_q.any | (|nb);
				if (!acc_q.f0v && lp_all.v0) begin
					acc_q.f0v <= 1'b1;
					acc_q.f0  <= {base[ID_W-1:3], lp_all.i0};
					acc_q.g0v <= lp_all.v1;
					acc_q.g0  <= {base[ID_W-1:3], lp_all.i1};
				end else if (acc_q.f0v && !acc_q.g0v && lp_all.v0) begin
					acc_q.g0v <= 1'b1;
					acc_q.g0  <= {base[ID_W-1:3], lp_all.i0};
				end
				if (!acc_q.f1v && lp_up.v0) begin
					acc_q.f1v <= 1'b1;
					acc_q.f1  <= {base[ID_W-1:3], lp_up.i0};
					acc_q.g1v <= lp_up.v1;
					acc_q.g1  <= {base[ID_W-1:3], lp_up.i1};
				end else if (acc_q.f1v && !acc_q.g1v && lp_up.v0) begin
					acc_q.g1v <= 1'b1;
					acc_q.g1  <= {base[ID_W-1:3], lp_up.i0};
				end
				if (cmd.func == FN_TEST && !cmd.ign && sel) begin
					acc_q.hit <= nb[cmd.target[2:0]];
				end
			end
		end
	end

	assign acc = acc_q;

endmodule
`default_nettype wire

// File: src/poll_target_bitmap_scheduler.sv
// Top level of the polling-target bitmap scheduler: handshakes, pointer and sequencer.
// Instantiates ptbs_scan and depends on ptbs_pkg.
//
// Channel   Signals                                          Direction
// input     in_valid/in_ready: func, target_id, range_last    in
// result    out_valid/out_ready: ignored ... current_valid    out
// config    cfg_valid/cfg_ready: repeat_enable                in
//
// Each request makes one pass over the bitmap memory, one byte a cycle, through its
// single read and single write port. After reset a clearing pass runs before the
// first request is accepted. A result waiting in the output register does not block
// the next request; a finished pass waits only while the previous result has not
// been taken.
`default_nettype none
module poll_target_bitmap_scheduler
	import ptbs_pkg::*;
#(
	parameter int MAX_ID = MAX_ID_DEF
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              in_valid,
	output logic                   in_ready,
	input  wire logic [FUNC_W-1:0] func,
	input  wire logic [ID_W-1:0]   target_id,
	input  wire logic [ID_W-1:0]   range_last,
	output logic                   out_valid,
	input  wire logic              out_ready,
	output logic                   ignored,
	output logic                   test_hit,
	output logic [ID_W-1:0]        chosen_id,
	output logic                   chosen_found,
	output logic [ID_W-1:0]        peek_id,
	output logic                   peek_found,
	output logic                   has_more,
	output logic                   any_set,
	output logic [ID_W-1:0]        current_id,
	output logic                   current_valid,
	input  wire logic              cfg_valid,
	output logic                   cfg_ready,
	input  wire logic              repeat_enable
);

	localparam int DEPTH = MAX_ID / 8 + 1;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
	localparam logic [ID_W-1:0] MAX_ID_V = ID_W'(MAX_ID);

	typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DRAIN, ST_DONE} state_t;

	state_t              state_q;
	logic                init_q;
	logic [AW-1:0]       addr_q;
	logic                repeat_q;
	logic [ID_W-1:0]     pos_q;
	logic                pos_valid_q;
	logic [FUNC_W-1:0]   func_q;
	logic [ID_W-1:0]     target_q;
	logic [ID_W-1:0]     last_q;
	logic [ID_W:0]       start_q;
	logic                ign_q;
	logic                accept;
	logic                ign_in;
	logic                res_load;
	scan_cmd_t           cmd;
	scan_acc_t           acc;

	logic                r_found;
	logic [ID_W-1:0]     r_pick;
	logic                r_pk_v;
	logic [ID_W-1:0]     r_pk;
	logic                r_more;
	logic                wrap_ok;

	assign in_ready  = (state_q == ST_IDLE);
	assign accept    = in_valid && in_ready;
	assign cfg_ready = 1'b1;
	assign res_load  = (state_q == ST_DONE) && !init_q && (!out_valid || out_ready);

	always_comb begin
		case (func)
			FN_SET_ONE, FN_REMOVE, FN_TEST: ign_in = (target_id > MAX_ID_V);
			FN_SET_RANGE: ign_in = (target_id > range_last) || (range_last > MAX_ID_V);
			FN_ADVANCE, FN_REWIND, FN_CLEAR: ign_in = 1'b0;
			default: ign_in = 1'b1;
		endcase
	end

	assign cmd.func   = func_q;
	assign cmd.target = target_q;
	assign cmd.last   = last_q;
	assign cmd.start  = start_q;
	assign cmd.ign    = ign_q;
	assign cmd.wipe   = init_q || (func_q == FN_CLEAR);

	ptbs_scan #(
		.MAX_ID(MAX_ID)
	) u_scan (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (state_q == ST_SCAN),
		.rd_addr (addr_q),
		.clr_acc (accept),
		.cmd     (cmd),
		.acc     (acc)
	);

	always_comb begin
		wrap_ok = repeat_q && acc.f0v;
		r_found = 1'b0;
		r_pick  = '0;
		r_pk_v  = 1'b0;
		r_pk    = '0;
		r_more  = repeat_q;
		if (func_q == FN_ADVANCE) begin
			if (acc.f1v) begin
				r_found = 1'b1;
				r_pick  = acc.f1;
				r_pk_v  = acc.g1v || wrap_ok;
				r_pk    = acc.g1v ? acc.g1 : (wrap_ok ? acc.f0 : '0);
				r_more  = repeat_q || acc.g1v;
			end else if (wrap_ok) begin
				r_found = 1'b1;
				r_pick  = acc.f0;
				r_pk_v  = 1'b1;
				r_pk    = acc.g0v ? acc.g0 : acc.f0;
				r_more  = 1'b1;
			end
		end else begin
			r_pk_v = acc.f1v || wrap_ok;
			r_pk   = acc.f1v ? acc.f1 : (wrap_ok ? acc.f0 : '0);
			r_more = repeat_q || acc.f1v;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			repeat_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			repeat_q <= repeat_enable;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_q   <= func;
			target_q <= target_id;
			last_q   <= range_last;
			ign_q    <= ign_in;
			if (func == FN_REWIND || func == FN_CLEAR || !pos_valid_q) begin
				start_q <= '0;
			end else begin
				start_q <= {1'b0, pos_q} + (ID_W + 1)'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_SCAN;
			init_q        <= 1'b1;
			addr_q        <= '0;
			pos_q         <= '0;
			pos_valid_q   <= 1'b0;
			out_valid     <= 1'b0;
			ignored       <= 1'b0;
			test_hit      <= 1'b0;
			chosen_id     <= '0;
			chosen_found  <= 1'b0;
			peek_id       <= '0;
			peek_found    <= 1'b0;
			has_more      <= 1'b0;
			any_set       <= 1'b0;
			current_id    <= '0;
			current_valid <= 1'b0;
		end else begin
			if (out_valid && out_ready && !res_load) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						addr_q  <= '0;
						state_q <= ST_SCAN;
						if (func == FN_REWIND || func == FN_CLEAR) begin
							pos_q       <= '0;
							pos_valid_q <= 1'b0;
						end
					end
				end
				ST_SCAN: begin
					if (addr_q == LAST_ADDR) begin
						state_q <= ST_DRAIN;
					end else begin
						addr_q <= addr_q + AW'(1);
					end
				end
				ST_DRAIN: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (init_q) begin
						init_q  <= 1'b0;
						state_q <= ST_IDLE;
					end else if (res_load) begin
						out_valid     <= 1'b1;
						ignored       <= ign_q;
						test_hit      <= acc.hit;
						chosen_id     <= r_pick;
						chosen_found  <= r_found;
						peek_id       <= r_pk;
						peek_found    <= r_pk_v;
						has_more      <= r_more;
						any_set       <= acc.any;
						if (r_found) begin
							pos_q         <= r_pick;
							pos_valid_q   <= 1'b1;
							current_id    <= r_pick;
							current_valid <= 1'b1;
						end else begin
							current_id    <= pos_q;
							current_valid <= pos_valid_q;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// File: tb/poll_target_bitmap_scheduler_test.sv
// Self-checking testbench for the polling-target bitmap scheduler.
// It mirrors the bitmap, the pointer and the repeat setting, and checks every status item.
// Depends on ptbs_pkg and poll_target_bitmap_scheduler.
`default_nettype none
module poll_target_bitmap_scheduler_test;
	import ptbs_pkg::*;

	localparam int CLK_PERIOD = 4;
	localparam int LAST_ADDR = MAX_ID_DEF;
	localparam int HOLD_CYCLES = 400;
	localparam int PHASE_REQUESTS = 110;
	localparam logic [FUNC_W-1:0] FN_UNUSED = 3'd7;

	typedef struct {
		logic [FUNC_W-1:0] func;
		logic [ID_W-1:0]   target;
		logic [ID_W-1:0]   last_id;
	} request_t;

	typedef struct packed {
		logic            ignored;
		logic            test_hit;
		logic [ID_W-1:0] chosen_id;
		logic            chosen_found;
		logic [ID_W-1:0] peek_id;
		logic            peek_found;
		logic            has_more;
		logic            any_set;
		logic [ID_W-1:0] current_id;
		logic            current_valid;
	} status_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [FUNC_W-1:0] func = '0;
	logic [ID_W-1:0] target_id = '0;
	logic [ID_W-1:0] range_last = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic ignored;
	logic test_hit;
	logic [ID_W-1:0] chosen_id;
	logic chosen_found;
	logic [ID_W-1:0] peek_id;
	logic peek_found;
	logic has_more;
	logic any_set;
	logic [ID_W-1:0] current_id;
	logic current_valid;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic repeat_enable = 1'b0;

	logic [255:0] presence = '0;
	logic [ID_W-1:0] ptr_id = '0;
	logic ptr_valid = 1'b0;
	logic rep_mode = 1'b0;

	request_t request_queue[$];
	status_t status_queue[$];
	int unsigned in_gap = 0;
	int unsigned out_gap = 0;
	logic no_gaps = 1'b0;
	logic hold_go = 1'b0;
	logic hold_out = 1'b0;
	int errors = 0;
	int n_checked = 0;
	int n_found = 0;
	int n_ignored = 0;
	int n_wrapped = 0;

	poll_target_bitmap_scheduler i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.func         (func),
		.target_id    (target_id),
		.range_last   (range_last),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.ignored      (ignored),
		.test_hit     (test_hit),
		.chosen_id    (chosen_id),
		.chosen_found (chosen_found),
		.peek_id      (peek_id),
		.peek_found   (peek_found),
		.has_more     (has_more),
		.any_set      (any_set),
		.current_id   (current_id),
		.current_valid(current_valid),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.repeat_enable(repeat_enable)
	);

	initial begin
		forever #(CLK_PERIOD / 2) clk = ~clk;
	end

	function automatic logic scan_up(input int lo, output logic [ID_W-1:0] hit);
		hit = '0;
		for (int a = lo; a <= LAST_ADDR; a++) begin
			if (presence[a]) begin
				hit = ID_W'(a);
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	function automatic int scan_origin();
		return ptr_valid ? int'(ptr_id) + 1 : 0;
	endfunction

	function automatic logic pick_next(output logic [ID_W-1:0] hit);
		if (scan_up(scan_origin(), hit))
			return 1'b1;
		if (rep_mode)
			return scan_up(0, hit);
		return 1'b0;
	endfunction

	function automatic status_t bitmap_step(input request_t rq);
		status_t s;
		logic [ID_W-1:0] hit;
		logic [ID_W-1:0] scratch;
		s = '0;
		case (rq.func)
			FN_SET_ONE, FN_REMOVE: begin
				if (rq.target > LAST_ADDR)
					s.ignored = 1'b1;
				else
					presence[rq.target] = (rq.func == FN_SET_ONE);
			end
			FN_SET_RANGE: begin
				if (rq.target > rq.last_id || rq.last_id > LAST_ADDR) begin
					s.ignored = 1'b1;
				end else begin
					for (int a = rq.target; a <= rq.last_id; a++)
						presence[a] = 1'b1;
				end
			end
			FN_TEST: begin
				if (rq.target > LAST_ADDR)
					s.ignored = 1'b1;
				else
					s.test_hit = presence[rq.target];
			end
			FN_ADVANCE: begin
				if (pick_next(hit)) begin
					ptr_id = hit;
					ptr_valid = 1'b1;
					s.chosen_id = hit;
					s.chosen_found = 1'b1;
				end
			end
			FN_REWIND: begin
				ptr_id = '0;
				ptr_valid = 1'b0;
			end
			FN_CLEAR: begin
				presence = '0;
				ptr_id = '0;
				ptr_valid = 1'b0;
			end
			default: begin
				s.ignored = 1'b1;
			end
		endcase
		s.peek_found = pick_next(hit);
		s.peek_id = hit;
		s.has_more = rep_mode || scan_up(scan_origin(), scratch);
		s.any_set = |presence;
		s.current_id = ptr_valid ? ptr_id : '0;
		s.current_valid = ptr_valid;
		return s;
	endfunction

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (no_gaps || r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic logic [ID_W-1:0] pick_addr();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (r < 6)
			return ID_W'($urandom_range(LAST_ADDR + 1, 255));
		if (r < 10)
			return '0;
		if (r < 14)
			return ID_W'(LAST_ADDR);
		if (r < 30)
			return ID_W'($urandom_range(0, 15));
		return ID_W'($urandom_range(0, LAST_ADDR));
	endfunction

	function automatic request_t random_request();
		request_t rq;
		int unsigned r;
		int unsigned hi;
		r = $urandom_range(0, 99);
		rq.target = pick_addr();
		rq.last_id = ID_W'($urandom_range(0, 255));
		if (r < 20)
			rq.func = FN_SET_ONE;
		else if (r < 28)
			rq.func = FN_SET_RANGE;
		else if (r < 42)
			rq.func = FN_REMOVE;
		else if (r < 56)
			rq.func = FN_TEST;
		else if (r < 90)
			rq.func = FN_ADVANCE;
		else if (r < 95)
			rq.func = FN_REWIND;
		else if (r < 97)
			rq.func = FN_CLEAR;
		else
			rq.func = FN_UNUSED;
		if (rq.func == FN_SET_RANGE) begin
			r = $urandom_range(0, 9);
			if (r == 0) begin
				rq.last_id = ID_W'($urandom_range(0, 254));
				rq.target = ID_W'($urandom_range(rq.last_id + 1, 255));
			end else if (r == 1) begin
				rq.last_id = ID_W'($urandom_range(LAST_ADDR + 1, 255));
				rq.target = ID_W'($urandom_range(0, rq.last_id));
			end else begin
				rq.target = ID_W'($urandom_range(0, LAST_ADDR));
				hi = rq.target + $urandom_range(0, 12);
				rq.last_id = ID_W'(hi > LAST_ADDR ? LAST_ADDR : hi);
			end
		end
		return rq;
	endfunction

	task automatic add_request(input logic [FUNC_W-1:0] f, input int t, input int l);
		request_t rq;
		rq.func = f;
		rq.target = ID_W'(t);
		rq.last_id = ID_W'(l);
		request_queue.push_back(rq);
	endtask

	// Sampled on the falling edge so that the queues and in_valid agree with each other.
	task automatic wait_idle();
		while (request_queue.size() != 0 || in_valid || status_queue.size() != 0)
			@(negedge clk);
	endtask

	task automatic write_repeat(input logic v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		repeat_enable <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		rep_mode = v;
	endtask

	task automatic compare_field(input string name, input logic [ID_W-1:0] want,
			input logic [ID_W-1:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			func <= '0;
			target_id <= '0;
			range_last <= '0;
			in_gap <= 0;
		end else begin
			request_t rq;
			logic busy;
			int unsigned g;
			busy = in_valid;
			g = in_gap;
			if (in_valid && in_ready) begin
				rq.func = func;
				rq.target = target_id;
				rq.last_id = range_last;
				status_queue.push_back(bitmap_step(rq));
				busy = 1'b0;
				g = pick_gap();
			end
			if (!busy) begin
				if (g != 0) begin
					in_gap <= g - 1;
					in_valid <= 1'b0;
				end else if (request_queue.size() != 0) begin
					rq = request_queue.pop_front();
					func <= rq.func;
					target_id <= rq.target;
					range_last <= rq.last_id;
					in_valid <= 1'b1;
					in_gap <= 0;
				end else begin
					in_valid <= 1'b0;
					in_gap <= 0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
			out_gap <= 0;
		end else begin
			status_t want;
			int unsigned g;
			g = out_gap;
			if (out_valid && out_ready) begin
				if (status_queue.size() == 0) begin
					$display("%0t: status item with no request outstanding", $time);
					errors++;
				end else begin
					want = status_queue.pop_front();
					compare_field("ignored", want.ignored, ignored);
					compare_field("test_hit", want.test_hit, test_hit);
					compare_field("chosen_id", want.chosen_id, chosen_id);
					compare_field("chosen_found", want.chosen_found, chosen_found);
					compare_field("peek_id", want.peek_id, peek_id);
					compare_field("peek_found", want.peek_found, peek_found);
					compare_field("has_more", want.has_more, has_more);
					compare_field("any_set", want.any_set, any_set);
					compare_field("current_id", want.current_id, current_id);
					compare_field("current_valid", want.current_valid, current_valid);
					n_checked++;
					n_found += want.chosen_found;
					n_ignored += want.ignored;
					if (want.chosen_found && want.peek_found && want.peek_id <= want.chosen_id)
						n_wrapped++;
				end
				g = pick_gap();
			end
			if (g != 0) begin
				out_gap <= g - 1;
				out_ready <= 1'b0;
			end else begin
				out_gap <= 0;
				out_ready <= !hold_out;
			end
		end
	end

	// Holds the status side off for a long stretch so that the input side backs up.
	initial begin
		wait (hold_go);
		@(posedge clk);
		hold_out <= 1'b1;
		repeat (HOLD_CYCLES) @(posedge clk);
		hold_out <= 1'b0;
	end

	initial begin
		#(CLK_PERIOD * 400000);
		$display("poll_target_bitmap_scheduler test failed");
		$finish;
	end

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		write_repeat(1'b0);
		add_request(FN_ADVANCE, 0, 0);
		add_request(FN_SET_ONE, 0, 0);
		add_request(FN_SET_ONE, LAST_ADDR, 0);
		add_request(FN_SET_ONE, 255, 255);
		add_request(FN_TEST, 0, 0);
		add_request(FN_TEST, 5, 0);
		add_request(FN_TEST, 255, 0);
		add_request(FN_SET_RANGE, 10, 12);
		add_request(FN_SET_RANGE, 12, 10);
		add_request(FN_SET_RANGE, 100, LAST_ADDR + 1);
		add_request(FN_ADVANCE, 0, 0);
		add_request(FN_REMOVE, 10, 0);
		add_request(FN_REMOVE, LAST_ADDR + 1, 0);
		repeat (4) add_request(FN_ADVANCE, 0, 0);
		add_request(FN_UNUSED, 0, 0);
		add_request(FN_REWIND, 0, 0);
		add_request(FN_CLEAR, 0, 0);
		wait_idle();

		write_repeat(1'b1);
		add_request(FN_ADVANCE, 0, 0);
		add_request(FN_SET_ONE, 3, 0);
		add_request(FN_ADVANCE, 0, 0);
		add_request(FN_ADVANCE, 0, 0);
		add_request(FN_SET_RANGE, 0, LAST_ADDR);
		add_request(FN_TEST, LAST_ADDR, 0);
		wait_idle();

		for (int p = 0; p < 6; p++) begin
			write_repeat(p[0]);
			no_gaps <= (p == 2);
			hold_go <= hold_go || (p == 4);
			for (int k = 0; k < PHASE_REQUESTS; k++)
				request_queue.push_back(random_request());
			wait_idle();
		end

		repeat (60) @(posedge clk);
		$display("Checked %0d status items: %0d advances found an address, %0d wrapped,",
			n_checked, n_found, n_wrapped);
		$display("%0d requests rejected, with repeat both on and off.", n_ignored);
		if (errors == 0 && status_queue.size() == 0)
			$display("poll_target_bitmap_scheduler test passed");
		else
			$display("poll_target_bitmap_scheduler test failed");
		$finish;
	end

endmodule
`default_nettype wire

// File: files.f
src/ptbs_pkg.sv
src/ptbs_scan.sv
src/poll_target_bitmap_scheduler.sv
tb/poll_target_bitmap_scheduler_test.sv
